>>> rtl/cfl_pkg.sv
`default_nettype none
package cfl_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // largest positive Q16.16 value and the clamp on the squared sound speed
  localparam logic [30:0] QMAX   = 31'h7fff_ffff;
  localparam logic [46:0] C2_MAX = 47'h7fff_ffff_ffff;
  localparam logic [20:0] ONE_Q  = 21'd65536;

  // divider / root unit sizes
  localparam int DS_NUM_W  = 64;
  localparam int DS_DEN_W  = 33;
  localparam int DS_QUO_W  = 50;
  localparam int DS_REM_W  = 36;
  localparam int DS_CNT_W  = 6;
  localparam logic [DS_CNT_W-1:0] DIV_STEPS  = 6'd50;
  localparam logic [DS_CNT_W-1:0] SQRT_STEPS = 6'd32;

  typedef enum logic [2:0] {
    REG_GAS_GAMMA      = 3'd0,
    REG_DENSITY_FLOOR  = 3'd1,
    REG_PRESSURE_FLOOR = 3'd2,
    REG_CELL_WIDTH_X   = 3'd3,
    REG_CELL_WIDTH_Y   = 3'd4,
    REG_CELL_WIDTH_Z   = 3'd5,
    REG_CFL_NUMBER     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ds_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_sts_t;

endpackage
`default_nettype wire

>>> rtl/cfl_divsqrt.sv
`default_nettype none
module cfl_divsqrt
  import cfl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ds_ctl_t             ctl,
  input  wire logic [DS_NUM_W-1:0] opa,
  input  wire logic [DS_DEN_W-1:0] opb,
  output ds_sts_t                  sts,
  output logic [DS_QUO_W-1:0]      quo
);

  logic [DS_NUM_W-1:0] num_r;
  logic [DS_DEN_W-1:0] den_r;
  logic [DS_REM_W-1:0] rem_r;
  logic [DS_QUO_W-1:0] quo_r;
  logic [DS_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic                sqrt_r;

  logic [DS_REM_W-1:0] shifted;
  logic [DS_REM_W-1:0] trial;
  logic [DS_REM_W-1:0] diff;
  logic                ge;
  logic                last_step;

  // one restoring step: one quotient bit, or one root bit from two radicand bits
  always_comb begin
    if (sqrt_r) begin
      shifted = {rem_r[DS_REM_W-3:0], num_r[DS_NUM_W-1 -: 2]};
      trial   = {2'b00, quo_r[31:0], 2'b01};
    end else begin
      shifted = {rem_r[DS_REM_W-2:0], num_r[DS_QUO_W-1]};
      trial   = {{(DS_REM_W-DS_DEN_W){1'b0}}, den_r};
    end
    diff      = shifted - trial;
    ge        = (shifted >= trial);
    last_step = (cnt_r == ((sqrt_r ? SQRT_STEPS : DIV_STEPS) - 6'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_step) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r  <= opa;
      den_r  <= opb;
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= '0;
      sqrt_r <= ctl.sqrt_mode;
    end else if (busy_r) begin
      rem_r <= ge ? diff : shifted;
      quo_r <= {quo_r[DS_QUO_W-2:0], ge};
      num_r <= sqrt_r ? {num_r[DS_NUM_W-3:0], 2'b00} : {num_r[DS_NUM_W-2:0], 1'b0};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule
`default_nettype wire

>>> rtl/cfl_time_step_estimate_unit.sv
`default_nettype none
// CFL time-step estimate for a 3-D ideal-gas grid, Q16.16 fixed point.
// in_* channel: one grid cell per transfer. in_tdata holds density,
// momentum_x, momentum_y, momentum_z and total_energy; in_tlast marks the
// last cell of the block. out_* channel: one step_limit per block, sent
// after the cell marked last, as the running minimum of the per-direction
// limits times cfl_number, saturated. The minimum then re-arms.
// cfg_*: plain register writes; the user must write only while no cell is in
// flight, as the block itself does not enforce it. One cell at a time;
// in_tready is low while a cell is worked. A single restoring divide/root
// unit does seven divides of 50 steps and one square root of 32 steps, and
// a shared multiplier does the products. The last cell of a block also
// passes S_OMUL and S_OUT before its result is loaded.
// A finished result waits in the output register; the next cell is accepted
// meanwhile, and only a following last cell stalls until out_tready.
// Reset: synchronous, active low; config registers take their defaults, the
// running minimum goes to the largest positive value and out_tvalid drops.
module cfl_time_step_estimate_unit
  import cfl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // density[30:0], momentum_x[62:31], momentum_y[94:63], momentum_z[126:95],
  // total_energy[158:127], zero pad[159]
  input  wire logic [159:0] in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // step_limit[30:0], zero pad[31]
  output logic [31:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [30:0]  cfg_wdata
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_VDIV = 14'b00000000000010,
    S_VMUL = 14'b00000000000100,
    S_VACC = 14'b00000000001000,
    S_KMUL = 14'b00000000010000,
    S_ESUB = 14'b00000000100000,
    S_PMUL = 14'b00000001000000,
    S_PSAT = 14'b00000010000000,
    S_GMUL = 14'b00000100000000,
    S_CDIV = 14'b00001000000000,
    S_SQRT = 14'b00010000000000,
    S_LDIV = 14'b00100000000000,
    S_OMUL = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [18:0] gamma_r;
  logic [16:0] rho_floor_r;
  logic [16:0] pr_floor_r;
  logic [30:0] width_r [3];
  logic [16:0] cfl_r;

  logic [30:0]        rho_r;
  logic signed [31:0] mom_r [3];
  logic signed [31:0] e_r, e_nxt;
  logic               last_r;
  logic [30:0]        rc_r;
  logic [31:0]        vm_r [3];
  logic [49:0]        s2_r;
  logic [30:0]        pr_r, pr_nxt;
  logic [46:0]        c2_r;
  logic [30:0]        c_r;
  logic [30:0]        min_r;
  logic [1:0]         d_r;
  logic signed [65:0] prod_r;
  logic               out_valid_r;
  logic [30:0]        out_data_r;
  logic               ds_start_r, ds_start_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic [DS_NUM_W-1:0] ds_opa;
  logic [DS_DEN_W-1:0] ds_opb;
  logic [DS_QUO_W-1:0] ds_quo;
  ds_ctl_t            ds_ctl;
  ds_sts_t            ds_sts;

  logic [30:0]        in_rho;
  logic [30:0]        in_rc;
  logic [31:0]        m_abs;
  logic [31:0]        vm_new;
  logic [30:0]        s2_sat;
  logic signed [20:0] gm1;
  logic signed [46:0] e_diff;
  logic [30:0]        lim;
  logic [49:0]        osh;

  assign in_rho = in_tdata[30:0];
  assign in_rc  = (in_rho > {14'd0, rho_floor_r}) ? in_rho :
                  ((rho_floor_r == 17'd0) ? 31'd1 : {14'd0, rho_floor_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r     <= 19'd91750;
      rho_floor_r <= 17'd1;
      pr_floor_r  <= 17'd1;
      width_r[0]  <= 31'd65536;
      width_r[1]  <= 31'd65536;
      width_r[2]  <= 31'd65536;
      cfl_r       <= 17'd32768;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAS_GAMMA:      gamma_r     <= cfg_wdata[18:0];
        REG_DENSITY_FLOOR:  rho_floor_r <= cfg_wdata[16:0];
        REG_PRESSURE_FLOOR: pr_floor_r  <= cfg_wdata[16:0];
        REG_CELL_WIDTH_X:   width_r[0]  <= cfg_wdata;
        REG_CELL_WIDTH_Y:   width_r[1]  <= cfg_wdata;
        REG_CELL_WIDTH_Z:   width_r[2]  <= cfg_wdata;
        REG_CFL_NUMBER:     cfl_r       <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // arithmetic helpers
  always_comb begin
    m_abs  = mom_r[d_r][31] ? 32'd0 - mom_r[d_r] : mom_r[d_r];
    if (ds_quo > {18'd0, mom_r[d_r][31], QMAX & {31{~mom_r[d_r][31]}}})
      vm_new = {mom_r[d_r][31], QMAX & {31{~mom_r[d_r][31]}}};
    else
      vm_new = ds_quo[31:0];
    s2_sat = (s2_r > {19'd0, QMAX}) ? QMAX : s2_r[30:0];
    gm1    = $signed({2'b00, gamma_r}) - $signed(ONE_Q);
    e_diff = 47'(e_r) - $signed({2'b00, prod_r[61:17]});
    if (e_diff > 47'sh7fff_ffff)
      e_nxt = 32'sh7fff_ffff;
    else if (e_diff < -47'sh8000_0000)
      e_nxt = 32'sh8000_0000;
    else
      e_nxt = e_diff[31:0];
    if (prod_r <= 66'sd0)
      pr_nxt = '0;
    else if (prod_r[65:16] > {19'd0, QMAX})
      pr_nxt = QMAX;
    else
      pr_nxt = prod_r[46:16];
    if (pr_nxt < {14'd0, pr_floor_r})
      pr_nxt = {14'd0, pr_floor_r};
    // a zero speed divides by zero and yields all ones, which saturates here
    lim = (ds_quo > {19'd0, QMAX}) ? QMAX : ds_quo[30:0];
    osh = prod_r[65:16];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_VMUL: begin
        mul_a = {1'b0, vm_r[d_r]};
        mul_b = {1'b0, vm_r[d_r]};
      end
      S_KMUL: begin
        mul_a = {2'b00, rho_r};
        mul_b = {2'b00, s2_sat};
      end
      S_PMUL: begin
        mul_a = 33'(gm1);
        mul_b = 33'(e_r);
      end
      S_GMUL: begin
        mul_a = {14'd0, gamma_r};
        mul_b = {2'b00, pr_r};
      end
      S_OMUL: begin
        mul_a = {2'b00, min_r};
        mul_b = {16'd0, cfl_r};
      end
      default: ;
    endcase
  end

  // divider / root operands
  always_comb begin
    ds_opa = '0;
    ds_opb = '0;
    unique case (state_r)
      S_VDIV: begin
        ds_opa = {16'd0, m_abs, 16'd0};
        ds_opb = {2'b00, rc_r};
      end
      S_CDIV: begin
        ds_opa = {14'd0, prod_r[49:0]};
        ds_opb = {2'b00, rc_r};
      end
      S_SQRT: begin
        ds_opa = {1'b0, c2_r, 16'd0};
      end
      S_LDIV: begin
        ds_opa = {17'd0, width_r[d_r], 16'd0};
        ds_opb = {1'b0, vm_r[d_r]} + {2'b00, c_r};
      end
      default: ;
    endcase
  end

  assign ds_ctl.start     = ds_start_r;
  assign ds_ctl.sqrt_mode = (state_r == S_SQRT);

  cfl_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ds_ctl),
    .opa   (ds_opa),
    .opb   (ds_opb),
    .sts   (ds_sts),
    .quo   (ds_quo)
  );

  always_comb begin
    state_nxt    = state_r;
    ds_start_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt    = S_VDIV;
          ds_start_nxt = 1'b1;
        end
      end
      S_VDIV: if (ds_sts.done) state_nxt = S_VMUL;
      S_VMUL: state_nxt = S_VACC;
      S_VACC: begin
        if (d_r == 2'd2) begin
          state_nxt = S_KMUL;
        end else begin
          state_nxt    = S_VDIV;
          ds_start_nxt = 1'b1;
        end
      end
      S_KMUL: state_nxt = S_ESUB;
      S_ESUB: state_nxt = S_PMUL;
      S_PMUL: state_nxt = S_PSAT;
      S_PSAT: state_nxt = S_GMUL;
      S_GMUL: begin
        state_nxt    = S_CDIV;
        ds_start_nxt = 1'b1;
      end
      S_CDIV: begin
        if (ds_sts.done) begin
          state_nxt    = S_SQRT;
          ds_start_nxt = 1'b1;
        end
      end
      S_SQRT: begin
        if (ds_sts.done) begin
          state_nxt    = S_LDIV;
          ds_start_nxt = 1'b1;
        end
      end
      S_LDIV: begin
        if (ds_sts.done) begin
          if (d_r != 2'd2)
            ds_start_nxt = 1'b1;
          else
            state_nxt = last_r ? S_OMUL : S_IDLE;
        end
      end
      S_OMUL: state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ds_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
      min_r       <= QMAX;
    end else begin
      state_r    <= state_nxt;
      ds_start_r <= ds_start_nxt;
      if (state_r == S_LDIV && ds_sts.done && lim < min_r)
        min_r <= lim;
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        min_r       <= QMAX;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rho_r    <= in_rho;
          mom_r[0] <= in_tdata[62:31];
          mom_r[1] <= in_tdata[94:63];
          mom_r[2] <= in_tdata[126:95];
          e_r      <= in_tdata[158:127];
          last_r   <= in_tlast;
          rc_r     <= in_rc;
          s2_r     <= '0;
          d_r      <= 2'd0;
        end
      end
      S_VDIV: if (ds_sts.done) vm_r[d_r] <= vm_new;
      S_VACC: begin
        s2_r <= s2_r + prod_r[65:16];
        d_r  <= (d_r == 2'd2) ? 2'd0 : d_r + 2'd1;
      end
      S_ESUB: e_r  <= e_nxt;
      S_PSAT: pr_r <= pr_nxt;
      S_CDIV: if (ds_sts.done) c2_r <= (ds_quo > {3'd0, C2_MAX}) ? C2_MAX : ds_quo[46:0];
      S_SQRT: if (ds_sts.done) c_r <= ds_quo[31] ? QMAX : ds_quo[30:0];
      S_LDIV: if (ds_sts.done) d_r <= (d_r == 2'd2) ? 2'd0 : d_r + 2'd1;
      S_OUT: begin
        if (!out_valid_r || out_tready)
          out_data_r <= (osh > {19'd0, QMAX}) ? QMAX : osh[30:0];
      end
      default: ;
    endcase
    if (state_r == S_VMUL || state_r == S_KMUL || state_r == S_PMUL ||
        state_r == S_GMUL || state_r == S_OMUL)
      prod_r <= mul_a * mul_b;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule
`default_nettype wire

>>> rtl/cfl_checker.sv
`default_nettype none
module cfl_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [31:0]  out_tdata
);

  // a result waiting for the receiver holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // one cell at a time: after a transfer the input side closes
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a cell is in work");

  // a new result is loaded only at the end of a cell's work
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared with no cell in work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind cfl_time_step_estimate_unit cfl_checker u_cfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> tb/tb_cfl_time_step_estimate_unit.sv
`default_nettype none
module tb_cfl_time_step_estimate_unit;
  import cfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] Q_MAX = 64'h7fff_ffff;
  localparam logic [63:0] C2_LIM = (64'd1 << 47) - 1;
  localparam int POST_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [30:0] cfg_wdata = '0;

  cfl_time_step_estimate_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL cfl_time_step_estimate_unit");
    $finish;
  end

  // predictor state
  logic [63:0] regs [7];
  logic [63:0] run_min;
  logic [30:0] step_q[$];
  int errors = 0;
  int cells_sent = 0;
  int blocks_seen = 0;
  bit quiet_out = 1'b0;
  bit sender_idle = 1'b1;

  function automatic logic [63:0] umin64(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // folds one cell into the running minimum, returns 1 when a step limit is due
  function automatic bit fold_cell(logic [159:0] d, logic last, output logic [30:0] step);
    logic [63:0] rho, rc, s2, ke, pr, c2, c, lim, spd, w, mag;
    logic signed [63:0] m, e, gm1, prod;
    logic [63:0] vm [3];
    rho = {33'd0, d[30:0]};
    rc = (rho > regs[REG_DENSITY_FLOOR]) ? rho : regs[REG_DENSITY_FLOOR];
    if (rc == 0) rc = 1;
    s2 = 0;
    for (int k = 0; k < 3; k++) begin
      m = {{32{d[31+32*k+31]}}, d[31+32*k +: 32]};
      mag = m[63] ? -m : m;
      vm[k] = umin64((mag << 16) / rc, m[63] ? Q_MAX + 1 : Q_MAX);
      s2 = s2 + ((vm[k] * vm[k]) >> 16);
    end
    s2 = umin64(s2, Q_MAX);
    ke = (rho * s2) >> 17;
    e = {{32{d[158]}}, d[158:127]};
    e = e - $signed(ke);
    if (e > $signed(Q_MAX)) e = Q_MAX;
    if (e < -$signed(Q_MAX) - 1) e = -$signed(Q_MAX) - 1;
    gm1 = $signed(regs[REG_GAS_GAMMA]) - 64'sd65536;
    prod = gm1 * e;
    pr = (prod > 0) ? (prod >> 16) : 0;
    pr = umin64(pr, Q_MAX);
    if (pr < regs[REG_PRESSURE_FLOOR]) pr = regs[REG_PRESSURE_FLOOR];
    c2 = umin64((regs[REG_GAS_GAMMA] * pr) / rc, C2_LIM);
    c = umin64(int_sqrt(c2 << 16), Q_MAX);
    for (int k = 0; k < 3; k++) begin
      w = regs[REG_CELL_WIDTH_X + k];
      spd = vm[k] + c;
      lim = (spd == 0) ? Q_MAX : umin64((w << 16) / spd, Q_MAX);
      if (lim < run_min) run_min = lim;
    end
    step = '0;
    if (last) begin
      step = 31'(umin64((run_min * regs[REG_CFL_NUMBER]) >> 16, Q_MAX));
      run_min = Q_MAX;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    int wd;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[30:0];
    wd = (idx == REG_GAS_GAMMA) ? 19 :
         (idx >= REG_CELL_WIDTH_X && idx <= REG_CELL_WIDTH_Z) ? 31 : 17;
    regs[idx] = val & ((64'd1 << wd) - 1);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block is idle once all results are in and the last cell has drained
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (step_q.size() != 0) @(posedge clk);
    repeat (POST_CYCLES) @(posedge clk);
  endtask

  task automatic send_cell(logic [159:0] d, logic last);
    logic [30:0] s;
    if (!quiet_out && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (fold_cell(d, last, s)) step_q.push_back(s);
    cells_sent++;
  endtask

  function automatic logic [159:0] pack_cell(logic [30:0] rho, logic [31:0] mx,
      logic [31:0] my, logic [31:0] mz, logic [31:0] en);
    return {1'b0, en, mz, my, mx, rho};
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 20) << 16;
      2: return -($urandom_range(0, 20) << 16);
      3: return $urandom_range(0, 4095);
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [30:0] rnd_rho();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd0;
      default: return 31'($urandom_range(1, 8) << 16);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        blocks_seen++;
        if (step_q.size() == 0) report("unexpected step limit", out_tdata, 0);
        else begin
          if (out_tdata !== {1'b0, step_q[0]})
            report("step_limit", out_tdata, {1'b0, step_q[0]});
          void'(step_q.pop_front());
        end
      end
      if (quiet_out || $urandom_range(0, 5) != 0) out_tready <= 1'b1;
      else out_tready <= 1'b0;
    end
  end

  task automatic test_corners();
    send_cell(pack_cell(31'd65536, 32'd0, 32'd0, 32'd0, 32'd65536), 1'b1);
    send_cell(pack_cell(31'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'h7fff_ffff), 1'b0);
    send_cell(pack_cell(31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                        32'h8000_0000), 1'b1);
    send_cell(pack_cell(31'd1, 32'hffff_ffff, 32'd0, 32'h8000_0000, 32'hffff_ffff), 1'b0);
    send_cell(pack_cell(31'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555), 1'b0);
    send_cell(pack_cell(31'h2aaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa), 1'b1);
    wait_idle();
    // zero density with zero density and pressure floors, gamma at one, then zero x width and cfl
    write_reg(REG_DENSITY_FLOOR, 0);
    write_reg(REG_GAS_GAMMA, 65536);
    write_reg(REG_PRESSURE_FLOOR, 0);
    send_cell(pack_cell(31'd0, 32'd0, 32'd0, 32'd0, 32'd0), 1'b1);
    send_cell(pack_cell(31'd0, 32'd5, 32'd0, 32'd0, 32'd100), 1'b1);
    wait_idle();
    write_reg(REG_CELL_WIDTH_X, 0);
    write_reg(REG_CFL_NUMBER, 0);
    send_cell(pack_cell(31'd65536, 32'd65536, 32'd0, 32'd0, 32'd65536), 1'b1);
    wait_idle();
    write_reg(REG_CFL_NUMBER, 31'h7fff_ffff);
    write_reg(REG_CELL_WIDTH_X, 31'h7fff_ffff);
    write_reg(REG_CELL_WIDTH_Y, 31'h7fff_ffff);
    write_reg(REG_CELL_WIDTH_Z, 31'h7fff_ffff);
    write_reg(REG_GAS_GAMMA, 31'h7fff_ffff);
    write_reg(REG_DENSITY_FLOOR, 31'h7fff_ffff);
    write_reg(REG_PRESSURE_FLOOR, 31'h7fff_ffff);
    send_cell(pack_cell(31'd65536, 32'd0, 32'd0, 32'd0, 32'h7fff_ffff), 1'b1);
    send_cell(pack_cell(31'd3, 32'd7, 32'h8000_0000, 32'd9, 32'h8000_0000), 1'b1);
    wait_idle();
  endtask

  task automatic random_phase(int cells, logic [63:0] gam, logic [63:0] df, logic [63:0] pf,
      logic [63:0] wx, logic [63:0] wy, logic [63:0] wz, logic [63:0] cfl);
    write_reg(REG_GAS_GAMMA, gam);
    write_reg(REG_DENSITY_FLOOR, df);
    write_reg(REG_PRESSURE_FLOOR, pf);
    write_reg(REG_CELL_WIDTH_X, wx);
    write_reg(REG_CELL_WIDTH_Y, wy);
    write_reg(REG_CELL_WIDTH_Z, wz);
    write_reg(REG_CFL_NUMBER, cfl);
    for (int i = 0; i < cells; i++)
      send_cell(pack_cell(rnd_rho(), rnd_word(), rnd_word(), rnd_word(), rnd_word()),
                ($urandom_range(0, 3) == 0) || (i == cells - 1));
    wait_idle();
  endtask

  task automatic test_random();
    random_phase(150, 91750, 1, 1, 65536, 65536, 65536, 32768);
    random_phase(150, 262144, 65536, 65536, 1, 2147483647, 1000, 65536);
    random_phase(150, 65537, 1, 1, $urandom_range(1, 1 << 20), $urandom(), 65536, 1);
    random_phase(100, $urandom_range(65537, 262144), $urandom_range(1, 65536),
                 $urandom_range(1, 65536), $urandom(), $urandom(), $urandom(),
                 $urandom_range(1, 65536));
  endtask

  task automatic test_no_stall();
    quiet_out = 1'b1;
    random_phase(80, 91750, 256, 256, 65536, 131072, 32768, 49152);
  endtask

  initial begin
    for (int k = 0; k < 7; k++) regs[k] = 0;
    regs[REG_GAS_GAMMA] = 91750;
    regs[REG_DENSITY_FLOOR] = 1;
    regs[REG_PRESSURE_FLOOR] = 1;
    regs[REG_CELL_WIDTH_X] = 65536;
    regs[REG_CELL_WIDTH_Y] = 65536;
    regs[REG_CELL_WIDTH_Z] = 65536;
    regs[REG_CFL_NUMBER] = 32768;
    run_min = Q_MAX;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random();
    test_no_stall();
    $display("covered %0d cells and %0d block results over corner and random register sets",
             cells_sent, blocks_seen);
    if (errors == 0) begin
      $display("PASS cfl_time_step_estimate_unit");
    end else begin
      $display("FAIL cfl_time_step_estimate_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
rtl/cfl_pkg.sv
rtl/cfl_divsqrt.sv
rtl/cfl_time_step_estimate_unit.sv
rtl/cfl_checker.sv
tb/tb_cfl_time_step_estimate_unit.sv
